>>> rtl/pca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_pkg
// Shared constants, lookup tables and blend arithmetic of the pixel color
// adjuster.
// ----------------------------------------------------------------------------
package pca_pkg;

    localparam int FRAC_BITS = 12;
    localparam int SCALE     = 1 << FRAC_BITS;

    localparam int LG_W   = FRAC_BITS + 3;
    // exp2 table is Q30 and reaches 1.0 at index 0
    localparam int EX_FRAC = 30;
    localparam int EX_W   = EX_FRAC + 1;
    localparam int MID_W  = FRAC_BITS + 1;
    localparam int GAM_W  = 16;
    localparam int BRI_W  = 13;
    localparam int FAC_W  = 19;
    localparam int LVL_W  = 8;
    localparam int CFG_W  = 19;
    localparam int IDX_W  = 3;
    localparam int D_W    = 20;
    localparam int SUM_W  = 32;
    localparam int T_W    = LG_W + GAM_W - FRAC_BITS;

    localparam int CHAN_STAGES = 10;
    localparam int SAT_STAGES  = 3;
    localparam int LATENCY     = CHAN_STAGES + SAT_STAGES;

    localparam logic [IDX_W-1:0] REG_GAMMA    = 3'd0;
    localparam logic [IDX_W-1:0] REG_BRIGHT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CONTRAST = 3'd2;
    localparam logic [IDX_W-1:0] REG_SAT      = 3'd3;
    localparam logic [IDX_W-1:0] REG_RED      = 3'd4;
    localparam logic [IDX_W-1:0] REG_GREEN    = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLUE     = 3'd6;

    typedef logic [LG_W-1:0]         t_lg_tab  [256];
    typedef logic [EX_W-1:0]         t_ex_tab  [256];
    typedef logic signed [MID_W-1:0] t_mid_tab [256];

    typedef struct packed {
        logic [GAM_W-1:0]        gamma;
        logic signed [BRI_W-1:0] bright;
        logic signed [FAC_W-1:0] contrast;
    } t_chan_cfg;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 64'd0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // restoring long division, used only while building tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q = 64'd0;
        rem = 65'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_ex_tab build_ex();
        t_ex_tab     tab;
        logic [63:0] root [8];
        logic [63:0] p;
        root[0] = isqrt64(64'd1 << 59);
        for (int k = 1; k < 8; k++) root[k] = isqrt64(root[k-1] << 30);
        for (int v = 0; v < 256; v++) begin
            p = 64'd1 << 30;
            for (int j = 7; j >= 0; j--) begin
                if (v[j]) p = (p * root[7-j]) >> 30;
            end
            tab[v] = p[EX_W-1:0];
        end
        return tab;
    endfunction

    function automatic t_lg_tab build_lg();
        t_lg_tab     tab;
        logic [63:0] y;
        logic [63:0] bits;
        int          k;
        tab[0] = '0;
        for (int v = 1; v < 256; v++) begin
            k = 0;
            while ((v << (k + 1)) <= 255) k++;
            y = udiv64(64'd255 << 30, 64'(v) << k);
            bits = 64'd0;
            for (int j = 0; j < FRAC_BITS; j++) begin
                y = (y * y) >> 30;
                bits = bits << 1;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    bits = bits | 64'd1;
                end
            end
            tab[v] = LG_W'((64'(k) << FRAC_BITS) | bits);
        end
        return tab;
    endfunction

    function automatic t_mid_tab build_mid();
        t_mid_tab   tab;
        longint     dd;
        longint     num;
        for (int v = 0; v < 256; v++) begin
            dd = longint'(v) - 127;
            num = 667 * (16129 - dd * dd) * (longint'(1) << FRAC_BITS);
            tab[v] = MID_W'(num / 16129000);
        end
        return tab;
    endfunction

    localparam t_lg_tab  LG_TAB  = build_lg();
    localparam t_ex_tab  EX_TAB  = build_ex();
    localparam t_mid_tab MID_TAB = build_mid();

    // o*S + (r-o)*d, the numerator of a blend
    function automatic logic signed [SUM_W-1:0] blend_sum(
        input logic [7:0] o, input logic [7:0] r, input logic signed [D_W-1:0] d);
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        a = SUM_W'($signed({1'b0, o}));
        b = SUM_W'($signed({1'b0, r})) - a;
        return (a <<< FRAC_BITS) + b * SUM_W'(d);
    endfunction

    // divide by S truncating toward zero, then clamp to 0..255
    function automatic logic [7:0] blend_fin(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = (s >= 0) ? (s >>> FRAC_BITS) : -((-s) >>> FRAC_BITS);
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/pca_chan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_chan
// One color channel: gamma, brightness, contrast and midtone balance, ten
// register stages.
// ----------------------------------------------------------------------------
module pca_chan (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire pca_pkg::t_chan_cfg           i_cfg,
    input  wire logic signed [pca_pkg::LVL_W-1:0] i_level,
    input  wire logic [7:0]                   i_v,
    output logic [7:0]                        o_x
);
    import pca_pkg::*;

    logic [7:0]       r1_v, r2_v, r3_v;
    logic [LG_W-1:0]  r1_lg;
    logic             r1_byp, r2_byp, r3_byp;
    logic             r1_zero, r2_zero, r3_zero;
    logic [T_W-1:0]   r2_t;
    logic [EX_W+7:0]  r3_p;
    logic [2:0]       r3_n;
    logic             r3_big;
    logic [7:0]       r4_g, r6_x, r8_x, r10_x;
    logic signed [SUM_W-1:0] r5_sum, r7_sum, r9_sum;

    logic [LG_W+GAM_W-1:0]   n_prod;
    logic signed [D_W-1:0]   n_bd;
    logic [7:0]              n_br;
    logic signed [SUM_W-1:0] n_off;

    always_comb begin
        n_prod = LG_W'(r1_lg) * (LG_W+GAM_W)'(i_cfg.gamma);
        if (i_cfg.bright > 0) begin
            n_bd = D_W'(i_cfg.bright);
            n_br = 8'd0;
        end else begin
            n_bd = -D_W'(i_cfg.bright);
            n_br = 8'd255;
        end
        n_off = (SUM_W'($signed({1'b0, r8_x})) <<< FRAC_BITS)
              + SUM_W'(i_level) * SUM_W'(MID_TAB[r8_x]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v    <= i_v;
            r1_lg   <= LG_TAB[i_v];
            r1_byp  <= (i_cfg.gamma == GAM_W'(SCALE));
            r1_zero <= (i_v == 8'd0);

            r2_v    <= r1_v;
            r2_byp  <= r1_byp;
            r2_zero <= r1_zero;
            r2_t    <= T_W'(n_prod >> FRAC_BITS);

            r3_v    <= r2_v;
            r3_byp  <= r2_byp;
            r3_zero <= r2_zero;
            r3_n    <= r2_t[FRAC_BITS+2:FRAC_BITS];
            r3_big  <= |r2_t[T_W-1:FRAC_BITS+3];
            r3_p    <= (EX_W+8)'(EX_TAB[r2_t[FRAC_BITS-1:FRAC_BITS-8]]) * (EX_W+8)'(255);

            if (r3_byp)                r4_g <= r3_v;
            else if (r3_zero || r3_big) r4_g <= 8'd0;
            else                       r4_g <= 8'(r3_p >> (EX_FRAC + 32'(r3_n)));

            r5_sum <= blend_sum(r4_g, n_br, n_bd);
            r6_x   <= blend_fin(r5_sum);
            r7_sum <= blend_sum(r6_x, 8'd127, D_W'(i_cfg.contrast));
            r8_x   <= blend_fin(r7_sum);
            r9_sum <= n_off;
            r10_x  <= blend_fin(r9_sum);
        end
    end

    assign o_x = r10_x;

endmodule
`default_nettype wire

>>> rtl/pca_sat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_sat
// Saturation blend of the three channels toward their lightness, three
// register stages.
// ----------------------------------------------------------------------------
module pca_sat (
    input  wire                                   i_clk,
    input  wire                                   i_en,
    input  wire logic signed [pca_pkg::FAC_W-1:0] i_sat,
    input  wire logic [7:0]                       i_r,
    input  wire logic [7:0]                       i_g,
    input  wire logic [7:0]                       i_b,
    output logic [7:0]                            o_r,
    output logic [7:0]                            o_g,
    output logic [7:0]                            o_b
);
    import pca_pkg::*;

    logic [7:0] n_mx, n_mn;
    logic [7:0] r1_r, r1_g, r1_b, r1_l, r2_r, r2_g, r2_b;
    logic       r1_on, r2_on;
    logic signed [SUM_W-1:0] r2_sr, r2_sg, r2_sb;
    logic [7:0] r3_r, r3_g, r3_b;
    logic [8:0] n_sum;

    always_comb begin
        n_mx = i_r;
        n_mn = i_r;
        if (i_g > n_mx) n_mx = i_g;
        if (i_b > n_mx) n_mx = i_b;
        if (i_g < n_mn) n_mn = i_g;
        if (i_b < n_mn) n_mn = i_b;
        n_sum = {1'b0, n_mx} + {1'b0, n_mn};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_r  <= i_r;
            r1_g  <= i_g;
            r1_b  <= i_b;
            r1_l  <= n_sum[8:1];
            r1_on <= (i_sat != '0);

            r2_r  <= r1_r;
            r2_g  <= r1_g;
            r2_b  <= r1_b;
            r2_on <= r1_on;
            r2_sr <= blend_sum(r1_r, r1_l, D_W'(i_sat));
            r2_sg <= blend_sum(r1_g, r1_l, D_W'(i_sat));
            r2_sb <= blend_sum(r1_b, r1_l, D_W'(i_sat));

            r3_r <= r2_on ? blend_fin(r2_sr) : r2_r;
            r3_g <= r2_on ? blend_fin(r2_sg) : r2_g;
            r3_b <= r2_on ? blend_fin(r2_sb) : r2_b;
        end
    end

    assign o_r = r3_r;
    assign o_g = r3_g;
    assign o_b = r3_b;

endmodule
`default_nettype wire

>>> rtl/pixel_color_adjust.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_adjust
// Gamma, brightness, contrast, color balance and saturation on RGBA pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock; the whole pipeline holds while the output is
// valid and stalled, so o_in_stall follows i_out_stall then. Ten stages per
// color channel (table lookups, at most one multiply or divide-and-clamp per
// stage), then three saturation stages. Registers are written through
// i_cfg_* while no pixel is in flight; the user must keep to this, the block does not enforce it.
module pixel_color_adjust (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_wr_en,
    input  wire logic [pca_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [pca_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [7:0]                   i_in_red,
    input  wire logic [7:0]                   i_in_green,
    input  wire logic [7:0]                   i_in_blue,
    input  wire logic [7:0]                   i_in_alpha,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [7:0]                        o_out_red,
    output logic [7:0]                        o_out_green,
    output logic [7:0]                        o_out_blue,
    output logic [7:0]                        o_out_alpha
);
    import pca_pkg::*;

    logic [GAM_W-1:0]        r_gamma;
    logic signed [BRI_W-1:0] r_bright;
    logic signed [FAC_W-1:0] r_contrast;
    logic signed [FAC_W-1:0] r_sat;
    logic signed [LVL_W-1:0] r_lvl_r, r_lvl_g, r_lvl_b;

    logic [LATENCY-1:0] r_vld;
    logic [7:0]     r_alpha [LATENCY];
    logic           en;
    t_chan_cfg      chan_cfg;
    logic [7:0]     ch_r, ch_g, ch_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma    <= GAM_W'(SCALE);
            r_bright   <= '0;
            r_contrast <= '0;
            r_sat      <= '0;
            r_lvl_r    <= '0;
            r_lvl_g    <= '0;
            r_lvl_b    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GAMMA:    r_gamma    <= i_cfg_data[GAM_W-1:0];
                REG_BRIGHT:   r_bright   <= i_cfg_data[BRI_W-1:0];
                REG_CONTRAST: r_contrast <= i_cfg_data[FAC_W-1:0];
                REG_SAT:      r_sat      <= i_cfg_data[FAC_W-1:0];
                REG_RED:      r_lvl_r    <= i_cfg_data[LVL_W-1:0];
                REG_GREEN:    r_lvl_g    <= i_cfg_data[LVL_W-1:0];
                REG_BLUE:     r_lvl_b    <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign en = !r_vld[LATENCY-1] || !i_out_stall;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_alpha[0] <= i_in_alpha;
            for (int k = 1; k < LATENCY; k++) r_alpha[k] <= r_alpha[k-1];
        end
    end

    assign chan_cfg = '{gamma: r_gamma, bright: r_bright, contrast: r_contrast};

    pca_chan u_chan_r (.i_clk, .i_en(en), .i_cfg(chan_cfg), .i_level(r_lvl_r),
                       .i_v(i_in_red), .o_x(ch_r));
    pca_chan u_chan_g (.i_clk, .i_en(en), .i_cfg(chan_cfg), .i_level(r_lvl_g),
                       .i_v(i_in_green), .o_x(ch_g));
    pca_chan u_chan_b (.i_clk, .i_en(en), .i_cfg(chan_cfg), .i_level(r_lvl_b),
                       .i_v(i_in_blue), .o_x(ch_b));

    pca_sat u_sat (
        .i_clk,
        .i_en  (en),
        .i_sat (r_sat),
        .i_r   (ch_r),
        .i_g   (ch_g),
        .i_b   (ch_b),
        .o_r   (o_out_red),
        .o_g   (o_out_green),
        .o_b   (o_out_blue)
    );

    assign o_out_valid = r_vld[LATENCY-1];
    assign o_out_alpha = r_alpha[LATENCY-1];

endmodule
`default_nettype wire

>>> rtl/pca_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_checker
// Port-level checks of the pixel color adjuster.
// ----------------------------------------------------------------------------
module pca_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input wire [7:0] o_out_red,
    input wire [7:0] o_out_alpha
);
    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid) else $error("valid after reset");

    // input is taken whenever no result is waiting
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall) else $error("stall with empty output");

    // a held output stalls the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall) else $error("no backpressure");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_red) && $stable(o_out_alpha)))
        else $error("stalled result changed");

endmodule

bind pixel_color_adjust pca_checker u_pca_checker (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
    .o_out_red, .o_out_alpha
);
`default_nettype wire

>>> bench/pixel_color_adjust_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_adjust_tb
// Self-checking bench for the pixel color adjuster. A behavioral model builds
// its own log, exp2 and midtone tables, predicts every output pixel and
// compares it with the DUT. The bench covers directed extremes of every
// register and random traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
module pixel_color_adjust_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pca_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int NUM_REGS = 7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_in_red;
    logic [7:0]       i_in_green;
    logic [7:0]       i_in_blue;
    logic [7:0]       i_in_alpha;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [7:0]       o_out_red;
    logic [7:0]       o_out_green;
    logic [7:0]       o_out_blue;
    logic [7:0]       o_out_alpha;

    pixel_color_adjust dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

    // model tables
    longint unsigned log_tab [256];
    longint unsigned exp_tab [256];
    longint          mid_tab [256];

    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    t_pixel           expected_px [$];
    int               pixels_sent;
    int               pixels_checked;
    int               fail_cnt;
    int               idle_pct;
    int               stall_pct;
    int               hold_req;
    int               hold_left;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int bit_i = 31; bit_i >= 0; bit_i--) begin
            t = r | (64'd1 << bit_i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    task automatic build_model_tables();
        longint unsigned roots [8];
        longint unsigned p;
        longint unsigned y;
        longint unsigned bits;
        longint          dd;
        int              k;
        roots[0] = int_sqrt(64'd1 << 59);
        for (int n = 1; n < 8; n++) roots[n] = int_sqrt(roots[n-1] << 30);
        for (int v = 0; v < 256; v++) begin
            p = 64'd1 << 30;
            for (int j = 7; j >= 0; j--) begin
                if (v[j]) p = (p * roots[7-j]) >> 30;
            end
            exp_tab[v] = p;
        end
        log_tab[0] = 0;
        for (int v = 1; v < 256; v++) begin
            k = 0;
            while ((v << (k + 1)) <= 255) k++;
            y = (64'd255 << 30) / (longint'(v) << k);
            bits = 0;
            for (int j = 0; j < FRAC_BITS; j++) begin
                y = (y * y) >> 30;
                bits = bits << 1;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    bits = bits | 1;
                end
            end
            log_tab[v] = (longint'(k) << FRAC_BITS) | bits;
        end
        for (int v = 0; v < 256; v++) begin
            dd = v - 127;
            mid_tab[v] = (667 * (16129 - dd * dd) * (longint'(1) << FRAC_BITS)) / 16129000;
        end
    endtask

    function automatic longint clamp_byte(input longint x);
        return (x < 0) ? 0 : ((x > 255) ? 255 : x);
    endfunction

    function automatic longint mix_toward(input longint o, input longint r, input longint d);
        return clamp_byte((o * (SCALE - d) + r * d) / SCALE);
    endfunction

    function automatic longint gamma_curve(input int v, input longint unsigned gam);
        longint unsigned t;
        longint unsigned n;
        int              frac_idx;
        if (gam == SCALE) return v;
        if (v == 0) return 0;
        t = (log_tab[v] * gam) >> FRAC_BITS;
        n = t >> FRAC_BITS;
        if (n >= 8) return 0;
        frac_idx = int'((t >> (FRAC_BITS - 8)) & 255);
        return longint'((255 * exp_tab[frac_idx]) >> (30 + n));
    endfunction

    function automatic longint adjust_channel(input int v, input longint level);
        longint unsigned gam;
        longint          bri;
        longint          con;
        longint          x;
        gam = cfg_reg[REG_GAMMA][GAM_W-1:0];
        bri = $signed(cfg_reg[REG_BRIGHT][BRI_W-1:0]);
        con = $signed(cfg_reg[REG_CONTRAST][FAC_W-1:0]);
        x = gamma_curve(v, gam);
        if (bri > 0) x = mix_toward(x, 0, bri);
        else x = mix_toward(x, 255, -bri);
        x = mix_toward(x, 127, con);
        return clamp_byte((x * SCALE + level * mid_tab[x]) / SCALE);
    endfunction

    function automatic t_pixel predict_pixel(input t_pixel src);
        longint c [3];
        longint sat;
        longint mx;
        longint mn;
        longint light;
        t_pixel res;
        c[0] = adjust_channel(src.red,   $signed(cfg_reg[REG_RED][LVL_W-1:0]));
        c[1] = adjust_channel(src.green, $signed(cfg_reg[REG_GREEN][LVL_W-1:0]));
        c[2] = adjust_channel(src.blue,  $signed(cfg_reg[REG_BLUE][LVL_W-1:0]));
        sat = $signed(cfg_reg[REG_SAT][FAC_W-1:0]);
        if (sat != 0) begin
            mx = c[0];
            mn = c[0];
            for (int j = 1; j < 3; j++) begin
                if (c[j] > mx) mx = c[j];
                if (c[j] < mn) mn = c[j];
            end
            light = (mx + mn) / 2;
            for (int j = 0; j < 3; j++) c[j] = mix_toward(c[j], light, sat);
        end
        res.red   = c[0][7:0];
        res.green = c[1][7:0];
        res.blue  = c[2][7:0];
        res.alpha = src.alpha;
        return res;
    endfunction

    // result checker and receiver stall generator
    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pixels_checked++;
            if (expected_px.size() == 0) begin
                $error("unexpected output transaction");
                fail_cnt++;
            end else begin
                exp_px = expected_px.pop_front();
                if (o_out_red !== exp_px.red) begin
                    $error("out_red expected %0d actual %0d", exp_px.red, o_out_red);
                    fail_cnt++;
                end
                if (o_out_green !== exp_px.green) begin
                    $error("out_green expected %0d actual %0d", exp_px.green, o_out_green);
                    fail_cnt++;
                end
                if (o_out_blue !== exp_px.blue) begin
                    $error("out_blue expected %0d actual %0d", exp_px.blue, o_out_blue);
                    fail_cnt++;
                end
                if (o_out_alpha !== exp_px.alpha) begin
                    $error("out_alpha expected %0d actual %0d", exp_px.alpha, o_out_alpha);
                    fail_cnt++;
                end
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one pixel, return at the edge where it is taken
    task automatic send_pixel(input t_pixel px);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_red   <= px.red;
        i_in_green <= px.green;
        i_in_blue  <= px.blue;
        i_in_alpha <= px.alpha;
        do @(posedge i_clk); while (o_in_stall);
        expected_px.push_back(predict_pixel(px));
        pixels_sent++;
    endtask

    task automatic send_rgba(input int r, input int g, input int b, input int a);
        send_pixel({r[7:0], g[7:0], b[7:0], a[7:0]});
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(t_pixel'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // writes every register from the shadow copy; pipeline must be empty
    task automatic apply_cfg();
        for (int idx = 0; idx < NUM_REGS; idx++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= IDX_W'(idx);
            i_cfg_data  <= cfg_reg[idx];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_cfg(input int gam, input int bri, input int con, input int sat,
                           input int red_l, input int green_l, input int blue_l);
        cfg_reg[REG_GAMMA]    = CFG_W'(gam);
        cfg_reg[REG_BRIGHT]   = CFG_W'(bri);
        cfg_reg[REG_CONTRAST] = CFG_W'(con);
        cfg_reg[REG_SAT]      = CFG_W'(sat);
        cfg_reg[REG_RED]      = CFG_W'(red_l);
        cfg_reg[REG_GREEN]    = CFG_W'(green_l);
        cfg_reg[REG_BLUE]     = CFG_W'(blue_l);
        apply_cfg();
    endtask

    task automatic randomize_cfg();
        int gam;
        int bri;
        int con;
        int sat;
        case ($urandom_range(9))
            0: gam = SCALE;
            1: gam = $urandom_range(65535);
            default: gam = $urandom_range(1, 40960);
        endcase
        bri = ($urandom_range(9) == 0) ? int'($urandom) : $urandom_range(8110) - 4055;
        con = ($urandom_range(4) == 0) ? -int'($urandom_range(262144)) :
              $urandom_range(8110) - 4055;
        case ($urandom_range(4))
            0: sat = 0;
            1: sat = -int'($urandom_range(262144));
            default: sat = $urandom_range(8110) - 4055;
        endcase
        if ($urandom_range(9) == 0) con = int'($urandom);
        set_cfg(gam, bri, con, sat, $urandom_range(198) - 99, $urandom_range(198) - 99,
                ($urandom_range(7) == 0) ? int'($urandom) : $urandom_range(198) - 99);
    endtask

    task automatic test_defaults();
        send_rgba(0, 0, 0, 0);
        send_rgba(255, 255, 255, 255);
        send_rgba(255, 0, 128, 170);
        send_rgba(85, 170, 1, 85);
        drain();
    endtask

    task automatic test_gamma_extremes();
        set_cfg(0, 0, 0, 0, 0, 0, 0);
        send_rgba(0, 1, 255, 7);
        set_cfg_after_drain(65535);
        send_rgba(255, 254, 0, 9);
        send_rgba(128, 200, 30, 11);
        set_cfg_after_drain(1);
        send_rgba(1, 100, 255, 13);
        drain();
    endtask

    task automatic set_cfg_after_drain(input int gam);
        drain();
        set_cfg(gam, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_blend_extremes();
        set_cfg(SCALE, 4095, 0, 0, 0, 0, 0);
        send_rgba(255, 100, 0, 1);
        drain();
        set_cfg(SCALE, -4096, 0, 0, 0, 0, 0);
        send_rgba(0, 100, 255, 2);
        drain();
        set_cfg(SCALE, 0, -262144, 0, 0, 0, 0);
        send_rgba(0, 126, 129, 3);
        send_rgba(255, 128, 127, 4);
        drain();
        set_cfg(20000, 0, 4055, -262144, 0, 0, 0);
        send_rgba(10, 200, 90, 5);
        drain();
        set_cfg(SCALE, 0, 0, 4055, 127, -128, 127);
        send_rgba(127, 60, 255, 6);
        send_rgba(0, 255, 200, 7);
        drain();
        // writes to the unused index must change nothing
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_UNUSED;
        i_cfg_data  <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        set_cfg(SCALE, -2000, 3000, -5000, -99, 99, -50);
        send_rgba(40, 127, 220, 8);
        send_rgba(255, 255, 255, 9);
        drain();
    endtask

    task automatic test_random_traffic(input int idle_p, input int stall_p);
        idle_pct  = idle_p;
        stall_pct = stall_p;
        for (int phase = 0; phase < 2; phase++) begin
            randomize_cfg();
            send_random(40);
            // let the pipeline run dry mid-phase
            drain();
            send_random(40);
            drain();
        end
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        randomize_cfg();
        hold_req = 80;
        send_random(50);
        drain();
    endtask

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_red    <= '0;
        i_in_green  <= '0;
        i_in_blue   <= '0;
        i_in_alpha  <= '0;
        i_out_stall <= 1'b0;
        pixels_sent = 0;
        pixels_checked = 0;
        fail_cnt = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        build_model_tables();
        cfg_reg[REG_GAMMA] = CFG_W'(SCALE);
        for (int idx = 1; idx < NUM_REGS; idx++) cfg_reg[idx] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_gamma_extremes();
        test_blend_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(80, 0);
        test_random_traffic(0, 80);
        test_random_traffic(33, 33);
        test_backpressure();
        drain();

        $display("covered %0d pixels (%0d checked): gamma, brightness, contrast,",
                 pixels_sent, pixels_checked);
        $display("balance and saturation extremes, random settings, idle and stall mixes");
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
